>>> sv/gregorian_to_bikram_sambat_date_macros.svh
// Assertion macros for the Gregorian to BS date converter.
// Used by the top level; no other dependencies.
`ifndef GREGORIAN_TO_BIKRAM_SAMBAT_DATE_MACROS_SVH
`define GREGORIAN_TO_BIKRAM_SAMBAT_DATE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define GBS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbs assertion failed: same-cycle implication");
// next-cycle implication
`define GBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbs assertion failed: next-cycle implication");
`else
`define GBS_ASSERT_SAME(label, clk, rst, ante, cons)
`define GBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/gbs_pkg.sv
// Shared widths, constants and types for the Gregorian to BS date converter.
// No dependencies.
`default_nettype none

package gbs_pkg;

   // field widths
   localparam int YEAR_W     = 12;
   localparam int YDAY_W     = 9;
   localparam int WDAY_W     = 3;
   localparam int TYEAR_W    = 7;
   localparam int TMON_W     = 4;
   localparam int MDAYS_W    = 6;
   localparam int MON_W      = 4;
   localparam int DAY_W      = 6;

   // month-length table geometry
   localparam int TABLE_YEARS     = 128;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int TABLE_DEPTH     = TABLE_YEARS * MONTHS_PER_YEAR;
   localparam int TABLE_ADDR_W    = $clog2(TABLE_DEPTH);
   localparam int YOFF_W          = $clog2(TABLE_YEARS + 1);
   localparam int CODE_W          = 2;
   localparam int MIN_MONTH_DAYS  = 29;

   // day counter: up to 4095 years of 366 days, plus sign
   localparam int REM_W      = 22;
   localparam int DAYS_COMMON_YEAR = 365;
   localparam int LEAP_CYCLE = 400;
   localparam int CENTURY    = 100;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [YEAR_W-1:0] EPOCH_GREG_YEAR_RST = 12'd1918;
   localparam logic [YDAY_W-1:0] EPOCH_GREG_YDAY_RST = 9'd102;
   localparam logic [YEAR_W-1:0] EPOCH_BS_YEAR_RST   = 12'd1975;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EPOCH_GREG_YEAR = 2'd0,
      CSR_EPOCH_GREG_YDAY = 2'd1,
      CSR_EPOCH_BS_YEAR   = 2'd2
   } csr_index_type;

   // request commands
   localparam logic CMD_CONVERT = 1'b0;
   localparam logic CMD_LOAD    = 1'b1;

   // table write request
   typedef struct packed {
      logic                    en;
      logic [TABLE_ADDR_W-1:0] addr;
      logic [CODE_W-1:0]       code;
   } table_write_type;

endpackage

`default_nettype wire

>>> sv/gbs_if.sv
// Valid/ready channel interfaces for the converter's request and result items.
// Depends on gbs_pkg.
`default_nettype none

interface gbs_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [gbs_pkg::YEAR_W-1:0]   greg_year;
   logic [gbs_pkg::YDAY_W-1:0]   year_day;
   logic [gbs_pkg::WDAY_W-1:0]   week_day;
   logic [gbs_pkg::TYEAR_W-1:0]  table_year;
   logic [gbs_pkg::TMON_W-1:0]   table_month;
   logic [gbs_pkg::MDAYS_W-1:0]  month_days;

   modport source (output valid, cmd, greg_year, year_day, week_day, table_year,
                   table_month, month_days, input ready);
   modport sink   (input valid, cmd, greg_year, year_day, week_day, table_year,
                   table_month, month_days, output ready);
endinterface

interface gbs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gbs_pkg::YEAR_W-1:0]  bs_year;
   logic [gbs_pkg::MON_W-1:0]   bs_month;
   logic [gbs_pkg::DAY_W-1:0]   bs_day;
   logic [gbs_pkg::WDAY_W-1:0]  bs_weekday;
   logic                        ok;

   modport source (output valid, bs_year, bs_month, bs_day, bs_weekday, ok,
                   input ready);
   modport sink   (input valid, bs_year, bs_month, bs_day, bs_weekday, ok,
                   output ready);
endinterface

`default_nettype wire

>>> sv/gregorian_to_bikram_sambat_date.sv
// Top level of the Gregorian to Bikram Sambat date converter: control FSM,
// day counting and month walk. Depends on gbs_pkg, gbs_if, gbs_month_table
// and the macro header.
//
//   channel | dir | handshake          | carries
//   req_if  | in  | valid/ready        | convert date or table load
//   rsp_if  | out | valid/ready        | BS date and ok, one per convert
//   csr_*   | in  | csr_we, no wait    | epoch registers 0..2
//
// A load writes one table entry. A convert reduces the epoch year mod 400,
// adds whole years up to greg_year, then walks the months, reading one table
// entry a cycle through the RAM read port (at most 1537 months).
// The result sits in an output register, so a new item is taken while it
// waits. Reset is synchronous and clears control state only; the table
// holds no valid state and must be loaded before it is read.
`default_nettype none
`include "gregorian_to_bikram_sambat_date_macros.svh"

module gregorian_to_bikram_sambat_date (
   input  wire logic                               clock,
   input  wire logic                               reset,
   gbs_req_if.sink                                 req_if,
   gbs_rsp_if.source                               rsp_if,
   input  wire logic                               csr_we,
   input  wire logic [gbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [gbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gbs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_YEARS,
      ST_WALK,
      ST_HOLD
   } state_type;

   // epoch registers
   logic [YEAR_W-1:0] epoch_gy_ff;
   logic [YDAY_W-1:0] epoch_yd_ff;
   logic [YEAR_W-1:0] epoch_bs_ff;

   // control and datapath registers
   state_type               state_ff, state_in;
   logic [YEAR_W-1:0]       gy_ff, gy_in;
   logic [WDAY_W-1:0]       wd_ff, wd_in;
   logic [YEAR_W-1:0]       y_ff, y_in;
   logic [YEAR_W-1:0]       m400_ff, m400_in;
   logic [6:0]              m100_ff, m100_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [TABLE_ADDR_W-1:0] iss_addr_ff, iss_addr_in;
   logic [MON_W-1:0]        iss_mon_ff, iss_mon_in;
   logic [YOFF_W-1:0]       iss_yoff_ff, iss_yoff_in;
   logic [MON_W-1:0]        ev_mon_ff, ev_mon_in;
   logic [YOFF_W-1:0]       ev_yoff_ff, ev_yoff_in;
   logic                    dv_ff, dv_in;

   // finished result waiting for the output register
   logic [YEAR_W-1:0] res_year_ff, res_year_in;
   logic [MON_W-1:0]  res_mon_ff, res_mon_in;
   logic [DAY_W-1:0]  res_day_ff, res_day_in;
   logic [WDAY_W-1:0] res_wd_ff, res_wd_in;
   logic              res_ok_ff, res_ok_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [YEAR_W-1:0] rsp_year_ff, rsp_year_in;
   logic [MON_W-1:0]  rsp_mon_ff, rsp_mon_in;
   logic [DAY_W-1:0]  rsp_day_ff, rsp_day_in;
   logic [WDAY_W-1:0] rsp_wd_ff, rsp_wd_in;
   logic              rsp_ok_ff, rsp_ok_in;

   logic                    req_accept;
   logic                    before_epoch;
   logic                    leap;
   logic [8:0]              m400_lo;
   logic [6:0]              m100_start;
   logic                    tbl_rd_en;
   logic [MDAYS_W-1:0]      tbl_days;
   table_write_type         tbl_wr;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.bs_year    = rsp_year_ff;
   assign rsp_if.bs_month   = rsp_mon_ff;
   assign rsp_if.bs_day     = rsp_day_ff;
   assign rsp_if.bs_weekday = rsp_wd_ff;
   assign rsp_if.ok         = rsp_ok_ff;

   // epoch registers
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_gy_ff <= EPOCH_GREG_YEAR_RST;
         epoch_yd_ff <= EPOCH_GREG_YDAY_RST;
         epoch_bs_ff <= EPOCH_BS_YEAR_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EPOCH_GREG_YEAR: epoch_gy_ff <= YEAR_W'(csr_wdata);
            CSR_EPOCH_GREG_YDAY: epoch_yd_ff <= csr_wdata[YDAY_W-1:0];
            CSR_EPOCH_BS_YEAR:   epoch_bs_ff <= YEAR_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // table load: entry holds month_days - 29, modulo 4
   always_comb begin
      tbl_wr.en   = req_accept && (req_if.cmd == CMD_LOAD) &&
                    (req_if.table_month < TMON_W'(MONTHS_PER_YEAR)) &&
                    (YOFF_W'(req_if.table_year) < YOFF_W'(TABLE_YEARS));
      tbl_wr.addr = TABLE_ADDR_W'(req_if.table_year) * TABLE_ADDR_W'(MONTHS_PER_YEAR) +
                    TABLE_ADDR_W'(req_if.table_month);
      tbl_wr.code = CODE_W'(req_if.month_days - MDAYS_W'(MIN_MONTH_DAYS));
   end

   // reads only happen in the walk and writes only in idle, so no overlap
   assign tbl_rd_en = (state_ff == ST_WALK) && (iss_yoff_ff < YOFF_W'(TABLE_YEARS));

   gbs_month_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_en   (tbl_rd_en),
      .rd_addr (iss_addr_ff),
      .rd_days (tbl_days)
   );

   assign before_epoch = (req_if.greg_year < epoch_gy_ff) ||
                         ((req_if.greg_year == epoch_gy_ff) &&
                          (req_if.year_day < epoch_yd_ff));

   // Gregorian leap rule from running year residues
   assign leap = (m400_ff == '0) || ((m100_ff != '0) && (y_ff[1:0] == 2'd0));

   // residue mod 100 of a value below 400
   assign m400_lo = m400_ff[8:0];
   always_comb begin
      if (m400_lo >= 9'd300) begin
         m100_start = 7'(m400_lo - 9'd300);
      end else if (m400_lo >= 9'd200) begin
         m100_start = 7'(m400_lo - 9'd200);
      end else if (m400_lo >= 9'(CENTURY)) begin
         m100_start = 7'(m400_lo - 9'(CENTURY));
      end else begin
         m100_start = 7'(m400_lo);
      end
   end

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      gy_in       = gy_ff;
      wd_in       = wd_ff;
      y_in        = y_ff;
      m400_in     = m400_ff;
      m100_in     = m100_ff;
      rem_in      = rem_ff;
      iss_addr_in = iss_addr_ff;
      iss_mon_in  = iss_mon_ff;
      iss_yoff_in = iss_yoff_ff;
      ev_mon_in   = ev_mon_ff;
      ev_yoff_in  = ev_yoff_ff;
      dv_in       = dv_ff;
      res_year_in = res_year_ff;
      res_mon_in  = res_mon_ff;
      res_day_in  = res_day_ff;
      res_wd_in   = res_wd_ff;
      res_ok_in   = res_ok_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_year_in  = rsp_year_ff;
      rsp_mon_in   = rsp_mon_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_wd_in    = rsp_wd_ff;
      rsp_ok_in    = rsp_ok_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_if.cmd == CMD_CONVERT)) begin
               gy_in   = req_if.greg_year;
               wd_in   = req_if.week_day;
               y_in    = epoch_gy_ff;
               m400_in = epoch_gy_ff;
               // day count starts at yd - epoch yday; whole years added later
               rem_in  = REM_W'(req_if.year_day) - REM_W'(epoch_yd_ff);
               if (before_epoch) begin
                  res_year_in = '0;
                  res_mon_in  = '0;
                  res_day_in  = '0;
                  res_wd_in   = '0;
                  res_ok_in   = 1'b0;
                  state_in    = ST_HOLD;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end

         // reduce the epoch year mod 400, one subtract a cycle
         ST_MOD: begin
            if (m400_ff >= YEAR_W'(LEAP_CYCLE)) begin
               m400_in = m400_ff - YEAR_W'(LEAP_CYCLE);
            end else begin
               m100_in  = m100_start;
               state_in = ST_YEARS;
            end
         end

         // add one whole Gregorian year a cycle
         ST_YEARS: begin
            if (y_ff == gy_ff) begin
               iss_addr_in = '0;
               iss_mon_in  = '0;
               iss_yoff_in = '0;
               dv_in       = 1'b0;
               state_in    = ST_WALK;
            end else begin
               rem_in  = rem_ff + REM_W'(DAYS_COMMON_YEAR) + REM_W'(leap);
               y_in    = y_ff + 1'b1;
               m400_in = (m400_ff == YEAR_W'(LEAP_CYCLE - 1)) ? '0 : m400_ff + 1'b1;
               m100_in = (m100_ff == 7'(CENTURY - 1)) ? '0 : m100_ff + 1'b1;
            end
         end

         // issue one table read a cycle, judge the month read last cycle
         ST_WALK: begin
            ev_mon_in   = iss_mon_ff;
            ev_yoff_in  = iss_yoff_ff;
            dv_in       = 1'b1;
            iss_addr_in = iss_addr_ff + 1'b1;
            if (iss_mon_ff == MON_W'(MONTHS_PER_YEAR - 1)) begin
               iss_mon_in  = '0;
               iss_yoff_in = iss_yoff_ff + 1'b1;
            end else begin
               iss_mon_in  = iss_mon_ff + 1'b1;
            end

            if (dv_ff) begin
               if (rem_ff[REM_W-1] || (rem_ff == '0)) begin
                  // no days left: first day of this month
                  res_year_in = epoch_bs_ff + YEAR_W'(ev_yoff_ff);
                  res_mon_in  = ev_mon_ff + 1'b1;
                  res_day_in  = DAY_W'(1);
                  res_wd_in   = wd_ff + 1'b1;
                  res_ok_in   = 1'b1;
                  state_in    = ST_HOLD;
               end else if (ev_yoff_ff >= YOFF_W'(TABLE_YEARS)) begin
                  // ran off the end of the table
                  res_year_in = '0;
                  res_mon_in  = '0;
                  res_day_in  = '0;
                  res_wd_in   = '0;
                  res_ok_in   = 1'b0;
                  state_in    = ST_HOLD;
               end else if (rem_ff < REM_W'(tbl_days)) begin
                  // date falls inside this month
                  res_year_in = epoch_bs_ff + YEAR_W'(ev_yoff_ff);
                  res_mon_in  = ev_mon_ff + 1'b1;
                  res_day_in  = rem_ff[DAY_W-1:0] + 1'b1;
                  res_wd_in   = wd_ff + 1'b1;
                  res_ok_in   = 1'b1;
                  state_in    = ST_HOLD;
               end else begin
                  rem_in = rem_ff - REM_W'(tbl_days);
               end
            end
         end

         // move the result into the output register once it is free
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_year_in  = res_year_ff;
               rsp_mon_in   = res_mon_ff;
               rsp_day_in   = res_day_ff;
               rsp_wd_in    = res_wd_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gy_ff       <= gy_in;
      wd_ff       <= wd_in;
      y_ff        <= y_in;
      m400_ff     <= m400_in;
      m100_ff     <= m100_in;
      rem_ff      <= rem_in;
      iss_addr_ff <= iss_addr_in;
      iss_mon_ff  <= iss_mon_in;
      iss_yoff_ff <= iss_yoff_in;
      ev_mon_ff   <= ev_mon_in;
      ev_yoff_ff  <= ev_yoff_in;
      res_year_ff <= res_year_in;
      res_mon_ff  <= res_mon_in;
      res_day_ff  <= res_day_in;
      res_wd_ff   <= res_wd_in;
      res_ok_ff   <= res_ok_in;
      rsp_year_ff <= rsp_year_in;
      rsp_mon_ff  <= rsp_mon_in;
      rsp_day_ff  <= rsp_day_in;
      rsp_wd_ff   <= rsp_wd_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   // checks
   `GBS_ASSERT_SAME(a_fail_is_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff, (rsp_year_ff == '0) && (rsp_mon_ff == '0) && (rsp_day_ff == '0) && (rsp_wd_ff == '0))
   `GBS_ASSERT_SAME(a_load_only_idle, clock, reset, tbl_wr.en, (state_ff == ST_IDLE) && !tbl_rd_en)
   `GBS_ASSERT_SAME(a_walk_in_bounds, clock, reset, dv_ff && (state_ff == ST_WALK), ev_yoff_ff <= YOFF_W'(TABLE_YEARS))
   `GBS_ASSERT_NEXT(a_hold_drains, clock, reset, (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_if.ready), rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

`default_nettype wire

>>> sv/gbs_month_table.sv
// Month-length table: 2-bit length codes in a synchronous RAM, one write
// and one registered read port; the read side returns the length in days.
// Depends on gbs_pkg.
`default_nettype none

module gbs_month_table (
   input  wire logic                                clock,
   input  wire gbs_pkg::table_write_type            wr,
   input  wire logic                                rd_en,
   input  wire logic [gbs_pkg::TABLE_ADDR_W-1:0]    rd_addr,
   output logic [gbs_pkg::MDAYS_W-1:0]              rd_days
);
   import gbs_pkg::*;

   logic [CODE_W-1:0] mem [TABLE_DEPTH];
   logic [CODE_W-1:0] rd_code_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.code;
      end
      if (rd_en) begin
         rd_code_ff <= mem[rd_addr];
      end
   end

   // code 0..3 stands for 29..32 days
   assign rd_days = MDAYS_W'(MIN_MONTH_DAYS) + MDAYS_W'(rd_code_ff);

endmodule

`default_nettype wire
